// ===== rtl/core/assert_macros.svh =====
// shared assertion macros for the rtl checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define BBVC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define BBVC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bbvc_pkg.sv =====
`default_nettype none
package bbvc_pkg;

   // stream payload widths
   localparam int REQ_DATA_W = 336;
   localparam int RSP_DATA_W = 96;

   // configuration port
   localparam int CFG_W     = 31;
   localparam int CFG_IDX_W = 3;

   localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR_ACCEL   = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR_ACCEL  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR_SPEED   = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR_SPEED  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_POSITION_TOLERANCE = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_TOLERANCE = 3'd5;

   // register values after reset
   localparam logic [CFG_W-1:0] RST_MAX_LINEAR_ACCEL   = 31'd196608;
   localparam logic [CFG_W-1:0] RST_MAX_ANGULAR_ACCEL  = 31'd655360;
   localparam logic [CFG_W-1:0] RST_MAX_LINEAR_SPEED   = 31'd131072;
   localparam logic [CFG_W-1:0] RST_MAX_ANGULAR_SPEED  = 31'd262144;
   localparam logic [CFG_W-1:0] RST_POSITION_TOLERANCE = 31'd655;
   localparam logic [CFG_W-1:0] RST_VELOCITY_TOLERANCE = 31'd655;

   // arithmetic unit sizes
   localparam int SQRT_IN_W = 66;
   localparam int DIV_DEN_W = 33;
   localparam int DIV_QUO_W = 31;

endpackage
`default_nettype wire

// ===== rtl/core/bbvc_sqrt.sv =====
`default_nettype none
module bbvc_sqrt #(
   parameter int IN_W = bbvc_pkg::SQRT_IN_W
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [IN_W-1:0]   radicand,
   output logic [IN_W/2-1:0]      root
);
   localparam int OUT_W = IN_W / 2;

   logic [IN_W-1:0]  rem_ff  [OUT_W-1];
   logic [OUT_W-1:0] root_ff [OUT_W];

   // one root bit resolved per stage, most significant first
   for (genvar i = 0; i < OUT_W; i++) begin : g_stage
      localparam int B = OUT_W - 1 - i;
      logic [IN_W-1:0]  rem_cur;
      logic [OUT_W-1:0] root_cur;
      logic [IN_W:0]    trial;
      logic             fits;

      if (i == 0) begin : g_first
         assign rem_cur  = radicand;
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[i-1];
         assign root_cur = root_ff[i-1];
      end

      // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 4^b
      assign trial = ((IN_W+1)'(root_cur) << (B + 1)) + ((IN_W+1)'(1) << (2 * B));
      assign fits  = {1'b0, rem_cur} >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[i] <= root_cur | (fits ? (OUT_W'(1) << B) : '0);
         end
      end

      if (i < OUT_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= fits ? rem_cur - trial[IN_W-1:0] : rem_cur;
            end
         end
      end
   end

   assign root = root_ff[OUT_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/bbvc_div.sv =====
`default_nettype none
module bbvc_div #(
   parameter int DEN_W = bbvc_pkg::DIV_DEN_W,
   parameter int QUO_W = bbvc_pkg::DIV_QUO_W
) (
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic [DEN_W+QUO_W-1:0]  dividend,
   input  wire logic [DEN_W-1:0]        divisor,
   output logic [QUO_W-1:0]             quotient
);
   localparam int NUM_W = DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W-1];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   // restoring long division, one quotient bit per stage
   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int B = QUO_W - 1 - i;
      logic [NUM_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [QUO_W-1:0] quo_cur;
      logic [NUM_W-1:0] trial;
      logic             fits;

      if (i == 0) begin : g_first
         assign rem_cur = dividend;
         assign den_cur = divisor;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[i-1];
         assign den_cur = den_ff[i-1];
         assign quo_cur = quo_ff[i-1];
      end

      assign trial = NUM_W'(den_cur) << B;
      assign fits  = rem_cur >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[i] <= quo_cur | (fits ? (QUO_W'(1) << B) : '0);
         end
      end

      if (i < QUO_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= fits ? rem_cur - trial : rem_cur;
               den_ff[i] <= den_cur;
            end
         end
      end
   end

   assign quotient = quo_ff[QUO_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/bang_bang_velocity_controller.sv =====
// bang-bang velocity controller
//
// req channel: one command per transfer (position, velocity, heading, spin
// rate, target point and heading, final speed, time step). rsp channel: one
// result per command (new x/y velocity and spin rate). csr channel: register
// writes, index and data, always ready; write only while the pipeline is empty.
//
// one command is taken every cycle unless a result is held by a low
// rsp_tready. the depth is set by two 33-stage square-root units and two
// 31-stage dividers, each resolving one bit per stage, plus eleven stages
// of multiply, add and compare around them.
//
// reset loads the register defaults and empties the pipeline.
// when rsp_tready is low with a result waiting, the whole pipeline holds and
// req_tready drops in the same cycle, so nothing is lost or repeated.
`default_nettype none
module bang_bang_velocity_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // pos_x, pos_y, vel_x, vel_y, heading, spin_rate, target_x, target_y,
   // final_speed, target_heading, time_step, one zero pad bit
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bbvc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // new_vel_x, new_vel_y, new_spin_rate
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bbvc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bbvc_pkg::CFG_IDX_W-1:0]    csr_index,
   input  wire logic [bbvc_pkg::CFG_W-1:0]        csr_data
);
   localparam int SQ_IN_W = bbvc_pkg::SQRT_IN_W;
   localparam int SQ_LAT  = bbvc_pkg::SQRT_IN_W / 2;
   localparam int DEN_W   = bbvc_pkg::DIV_DEN_W;
   localparam int DIV_LAT = bbvc_pkg::DIV_QUO_W;
   localparam int NUM_W   = bbvc_pkg::DIV_DEN_W + bbvc_pkg::DIV_QUO_W;
   localparam int DEPTH   = 11 + 2 * SQ_LAT + 2 * DIV_LAT;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] da;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] w;
      logic [30:0]        fs;
      logic [15:0]        dt;
   } s1_type;

   typedef struct packed {
      logic [65:0] dx2;
      logic [65:0] dy2;
      logic [63:0] vx2;
      logic [63:0] vy2;
      logic [63:0] w2;
      logic [64:0] arhs;
      logic [30:0] step;
      logic [30:0] astep;
      logic [32:0] adx;
      logic [32:0] ady;
      logic        dx_neg;
      logic        dy_neg;
      logic        da_neg;
      logic        tox;
      logic        toy;
      logic        angwin;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] w;
      logic [30:0] fs;
      logic        dtz;
   } s2_type;

   typedef struct packed {
      logic        dx_neg;
      logic        dy_neg;
      logic [32:0] adx;
      logic [32:0] ady;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] w;
      logic [30:0] fs;
      logic        dtz;
      logic [30:0] step;
      logic [30:0] astep;
      logic        da_neg;
      logic        csr;
      logic        angwin;
      logic        tox;
      logic        toy;
      logic [63:0] vsq;
   } sa_type;

   typedef struct packed {
      logic [63:0] numx;
      logic [63:0] numy;
      logic [64:0] rmul;
      logic [32:0] dlen;
      logic        linwin;
      logic        distz;
      logic [32:0] nwraw;
      logic        tox;
      logic        toy;
      logic        dx_neg;
      logic        dy_neg;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] w;
      logic [30:0] fs;
      logic        dtz;
      logic        angwin;
      logic [63:0] vsq;
   } p1_type;

   typedef struct packed {
      logic [63:0] numx;
      logic [63:0] numy;
      logic [32:0] dlen;
      logic [65:0] rhs;
      logic [31:0] nw;
      logic        tox;
      logic        toy;
      logic        dx_neg;
      logic        dy_neg;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] w;
      logic        dtz;
      logic        angwin;
      logic        linwin;
      logic        distz;
      logic [63:0] vsq;
   } p2_type;

   typedef struct packed {
      logic        subx;
      logic        suby;
      logic        distz;
      logic        linwin;
      logic [31:0] nw;
      logic        angwin;
      logic        dtz;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] w;
   } sb_type;

   typedef struct packed {
      logic [32:0] nx;
      logic [32:0] ny;
      logic        linwin;
      logic [31:0] nw;
      logic        angwin;
      logic        dtz;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] w;
   } n1_type;

   typedef struct packed {
      logic [32:0] nx;
      logic [32:0] ny;
      logic [31:0] anx;
      logic [31:0] any;
      logic [63:0] nx2;
      logic [63:0] ny2;
      logic        linwin;
      logic [31:0] nw;
      logic        angwin;
      logic        dtz;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] w;
   } n2_type;

   typedef struct packed {
      logic [32:0] nx;
      logic [32:0] ny;
      logic [31:0] anx;
      logic [31:0] any;
      logic        linwin;
      logic [31:0] nw;
      logic        angwin;
      logic        dtz;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] w;
   } sc_type;

   typedef struct packed {
      logic        nx_neg;
      logic        ny_neg;
      logic        over;
      logic        lenz;
      logic [31:0] nxl;
      logic [31:0] nyl;
      logic        linwin;
      logic [31:0] nw;
      logic        angwin;
      logic        dtz;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] w;
   } sd_type;

   function automatic logic [32:0] mag33(input logic [32:0] v);
      return v[32] ? -v : v;
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   // configuration registers
   logic [bbvc_pkg::CFG_W-1:0] accel_ff, alpha_ff, maxls_ff, maxas_ff, ptol_ff, vtol_ff;

   // pipeline control
   logic             advance;
   logic [DEPTH-1:0] vld_ff;

   // stage registers
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   sa_type s3_ff, s3_in;
   logic [SQ_IN_W-1:0] s3_dsq_ff, s3_dsq_in;
   sa_type sa_ff [SQ_LAT];
   logic [DEN_W-1:0] dlen, speed;
   p1_type p1_ff, p1_in;
   p2_type p2_ff, p2_in;
   sb_type p3_ff, p3_in;
   logic [NUM_W-1:0] p3_numx_ff, p3_numy_ff;
   logic [DEN_W-1:0] p3_dist_ff;
   sb_type sb_ff [DIV_LAT];
   logic [bbvc_pkg::DIV_QUO_W-1:0] qx, qy;
   n1_type n1_ff, n1_in;
   n2_type n2_ff, n2_in;
   sc_type n3_ff, n3_in;
   logic [SQ_IN_W-1:0] n3_lsq_ff, n3_lsq_in;
   sc_type sc_ff [SQ_LAT];
   logic [DEN_W-1:0] len;
   sd_type l1_ff, l1_in;
   logic [NUM_W-1:0] l1_mulx_ff, l1_mulx_in, l1_muly_ff, l1_muly_in;
   logic [DEN_W-1:0] l1_len_ff;
   sd_type sd_ff [DIV_LAT];
   logic [bbvc_pkg::DIV_QUO_W-1:0] rx, ry;
   logic [bbvc_pkg::RSP_DATA_W-1:0] out_ff, out_in;

   // configuration writes, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= bbvc_pkg::RST_MAX_LINEAR_ACCEL;
         alpha_ff <= bbvc_pkg::RST_MAX_ANGULAR_ACCEL;
         maxls_ff <= bbvc_pkg::RST_MAX_LINEAR_SPEED;
         maxas_ff <= bbvc_pkg::RST_MAX_ANGULAR_SPEED;
         ptol_ff  <= bbvc_pkg::RST_POSITION_TOLERANCE;
         vtol_ff  <= bbvc_pkg::RST_VELOCITY_TOLERANCE;
      end else if (csr_valid) begin
         unique case (csr_index)
            bbvc_pkg::REG_MAX_LINEAR_ACCEL:   accel_ff <= csr_data;
            bbvc_pkg::REG_MAX_ANGULAR_ACCEL:  alpha_ff <= csr_data;
            bbvc_pkg::REG_MAX_LINEAR_SPEED:   maxls_ff <= csr_data;
            bbvc_pkg::REG_MAX_ANGULAR_SPEED:  maxas_ff <= csr_data;
            bbvc_pkg::REG_POSITION_TOLERANCE: ptol_ff  <= csr_data;
            bbvc_pkg::REG_VELOCITY_TOLERANCE: vtol_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless the finished result is held
   assign advance    = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // stage 1: target deltas
   always_comb begin
      s1_in.dx = {req_tdata[223], req_tdata[223:192]} - {req_tdata[31], req_tdata[31:0]};
      s1_in.dy = {req_tdata[255], req_tdata[255:224]} - {req_tdata[63], req_tdata[63:32]};
      s1_in.da = {req_tdata[318], req_tdata[318:287]} - {req_tdata[159], req_tdata[159:128]};
      s1_in.vx = req_tdata[95:64];
      s1_in.vy = req_tdata[127:96];
      s1_in.w  = req_tdata[191:160];
      s1_in.fs = req_tdata[286:256];
      s1_in.dt = req_tdata[334:319];
   end

   // stage 2: squares, acceleration steps, direction tests
   always_comb begin
      logic [32:0] adx, ady, dam;
      logic [31:0] avx, avy, aw;
      logic [46:0] lprod, aprod;
      adx   = mag33(s1_ff.dx);
      ady   = mag33(s1_ff.dy);
      dam   = mag33(s1_ff.da);
      avx   = mag32(s1_ff.vx);
      avy   = mag32(s1_ff.vy);
      aw    = mag32(s1_ff.w);
      lprod = accel_ff * s1_ff.dt;
      aprod = alpha_ff * s1_ff.dt;
      s2_in.dx2    = adx * adx;
      s2_in.dy2    = ady * ady;
      s2_in.vx2    = avx * avx;
      s2_in.vy2    = avy * avy;
      s2_in.w2     = aw * aw;
      s2_in.arhs   = {alpha_ff, 1'b0} * dam;
      s2_in.step   = lprod[46:16];
      s2_in.astep  = aprod[46:16];
      s2_in.adx    = adx;
      s2_in.ady    = ady;
      s2_in.dx_neg = s1_ff.dx[32];
      s2_in.dy_neg = s1_ff.dy[32];
      s2_in.da_neg = s1_ff.da[32];
      s2_in.tox    = (s1_ff.dx != '0) && (s1_ff.vx != '0) && (s1_ff.dx[32] == s1_ff.vx[31]);
      s2_in.toy    = (s1_ff.dy != '0) && (s1_ff.vy != '0) && (s1_ff.dy[32] == s1_ff.vy[31]);
      s2_in.angwin = (dam <= {2'b00, ptol_ff}) && (aw <= {1'b0, vtol_ff});
      s2_in.vx     = s1_ff.vx;
      s2_in.vy     = s1_ff.vy;
      s2_in.w      = s1_ff.w;
      s2_in.fs     = s1_ff.fs;
      s2_in.dtz    = (s1_ff.dt == '0);
   end

   // stage 3: sums of squares and the can-stop-rotate test
   always_comb begin
      s3_dsq_in     = s2_ff.dx2 + s2_ff.dy2;
      s3_in.dx_neg  = s2_ff.dx_neg;
      s3_in.dy_neg  = s2_ff.dy_neg;
      s3_in.adx     = s2_ff.adx;
      s3_in.ady     = s2_ff.ady;
      s3_in.vx      = s2_ff.vx;
      s3_in.vy      = s2_ff.vy;
      s3_in.w       = s2_ff.w;
      s3_in.fs      = s2_ff.fs;
      s3_in.dtz     = s2_ff.dtz;
      s3_in.step    = s2_ff.step;
      s3_in.astep   = s2_ff.astep;
      s3_in.da_neg  = s2_ff.da_neg;
      s3_in.csr     = {1'b0, s2_ff.w2} <= s2_ff.arhs;
      s3_in.angwin  = s2_ff.angwin;
      s3_in.tox     = s2_ff.tox;
      s3_in.toy     = s2_ff.toy;
      s3_in.vsq     = s2_ff.vx2 + s2_ff.vy2;
   end

   // distance and speed
   bbvc_sqrt #(.IN_W(SQ_IN_W)) u_sqrt_dist (
      .clock(clock), .en(advance), .radicand(s3_dsq_ff), .root(dlen)
   );

   bbvc_sqrt #(.IN_W(SQ_IN_W)) u_sqrt_speed (
      .clock(clock), .en(advance), .radicand({2'b00, s3_ff.vsq}), .root(speed)
   );

   // post-root stage 1: step products, stop window, raw spin
   always_comb begin
      sa_type sa_o;
      logic        neg;
      logic [32:0] we, ae;
      sa_o = sa_ff[SQ_LAT-1];
      neg  = sa_o.da_neg ^ !sa_o.csr;
      we   = {sa_o.w[31], sa_o.w};
      ae   = {2'b00, sa_o.astep};
      p1_in.numx   = sa_o.adx * sa_o.step;
      p1_in.numy   = sa_o.ady * sa_o.step;
      p1_in.rmul   = {accel_ff, 1'b0} * dlen;
      p1_in.dlen   = dlen;
      p1_in.linwin = (dlen <= {2'b00, ptol_ff}) && (speed <= {2'b00, vtol_ff})
                     && (sa_o.fs == '0);
      p1_in.distz  = (dlen == '0);
      p1_in.nwraw  = neg ? we - ae : we + ae;
      p1_in.tox    = sa_o.tox;
      p1_in.toy    = sa_o.toy;
      p1_in.dx_neg = sa_o.dx_neg;
      p1_in.dy_neg = sa_o.dy_neg;
      p1_in.vx     = sa_o.vx;
      p1_in.vy     = sa_o.vy;
      p1_in.w      = sa_o.w;
      p1_in.fs     = sa_o.fs;
      p1_in.dtz    = sa_o.dtz;
      p1_in.angwin = sa_o.angwin;
      p1_in.vsq    = sa_o.vsq;
   end

   // post-root stage 2: stopping budget, spin clamp
   always_comb begin
      logic signed [32:0] nwr, lim, nwc;
      nwr = p1_ff.nwraw;
      lim = {2'b00, maxas_ff};
      if (nwr > lim) begin
         nwc = lim;
      end else if (nwr < -lim) begin
         nwc = -lim;
      end else begin
         nwc = nwr;
      end
      p2_in.numx   = p1_ff.numx;
      p2_in.numy   = p1_ff.numy;
      p2_in.dlen   = p1_ff.dlen;
      p2_in.rhs    = {1'b0, p1_ff.rmul} + {19'b0, p1_ff.fs, 16'b0};
      p2_in.nw     = nwc[31:0];
      p2_in.tox    = p1_ff.tox;
      p2_in.toy    = p1_ff.toy;
      p2_in.dx_neg = p1_ff.dx_neg;
      p2_in.dy_neg = p1_ff.dy_neg;
      p2_in.vx     = p1_ff.vx;
      p2_in.vy     = p1_ff.vy;
      p2_in.w      = p1_ff.w;
      p2_in.dtz    = p1_ff.dtz;
      p2_in.angwin = p1_ff.angwin;
      p2_in.linwin = p1_ff.linwin;
      p2_in.distz  = p1_ff.distz;
      p2_in.vsq    = p1_ff.vsq;
   end

   // post-root stage 3: can-stop test and step signs per axis
   always_comb begin
      logic cs, gxn, gyn;
      cs = {2'b00, p2_ff.vsq} <= p2_ff.rhs;
      if (p2_ff.tox && p2_ff.toy) begin
         gxn = !cs;
         gyn = !cs;
      end else if (p2_ff.tox) begin
         gxn = !cs;
         gyn = cs;
      end else if (p2_ff.toy) begin
         gyn = !cs;
         gxn = cs;
      end else begin
         gxn = 1'b0;
         gyn = 1'b0;
      end
      p3_in.subx   = p2_ff.dx_neg ^ gxn;
      p3_in.suby   = p2_ff.dy_neg ^ gyn;
      p3_in.distz  = p2_ff.distz;
      p3_in.linwin = p2_ff.linwin;
      p3_in.nw     = p2_ff.nw;
      p3_in.angwin = p2_ff.angwin;
      p3_in.dtz    = p2_ff.dtz;
      p3_in.vx     = p2_ff.vx;
      p3_in.vy     = p2_ff.vy;
      p3_in.w      = p2_ff.w;
   end

   // axis steps: step * |d| / distance
   bbvc_div #(.DEN_W(DEN_W), .QUO_W(DIV_LAT)) u_div_x (
      .clock(clock), .en(advance), .dividend(p3_numx_ff), .divisor(p3_dist_ff),
      .quotient(qx)
   );

   bbvc_div #(.DEN_W(DEN_W), .QUO_W(DIV_LAT)) u_div_y (
      .clock(clock), .en(advance), .dividend(p3_numy_ff), .divisor(p3_dist_ff),
      .quotient(qy)
   );

   // new velocity before the speed limit
   always_comb begin
      sb_type sb_o;
      logic [32:0] qxe, qye, vxe, vye;
      sb_o = sb_ff[DIV_LAT-1];
      qxe  = sb_o.distz ? '0 : {2'b00, qx};
      qye  = sb_o.distz ? '0 : {2'b00, qy};
      vxe  = {sb_o.vx[31], sb_o.vx};
      vye  = {sb_o.vy[31], sb_o.vy};
      n1_in.nx     = sb_o.subx ? vxe - qxe : vxe + qxe;
      n1_in.ny     = sb_o.suby ? vye - qye : vye + qye;
      n1_in.linwin = sb_o.linwin;
      n1_in.nw     = sb_o.nw;
      n1_in.angwin = sb_o.angwin;
      n1_in.dtz    = sb_o.dtz;
      n1_in.vx     = sb_o.vx;
      n1_in.vy     = sb_o.vy;
      n1_in.w      = sb_o.w;
   end

   // squares of the new components
   always_comb begin
      logic [32:0] anxw, anyw;
      anxw = mag33(n1_ff.nx);
      anyw = mag33(n1_ff.ny);
      n2_in.nx     = n1_ff.nx;
      n2_in.ny     = n1_ff.ny;
      n2_in.anx    = anxw[31:0];
      n2_in.any    = anyw[31:0];
      n2_in.nx2    = anxw[31:0] * anxw[31:0];
      n2_in.ny2    = anyw[31:0] * anyw[31:0];
      n2_in.linwin = n1_ff.linwin;
      n2_in.nw     = n1_ff.nw;
      n2_in.angwin = n1_ff.angwin;
      n2_in.dtz    = n1_ff.dtz;
      n2_in.vx     = n1_ff.vx;
      n2_in.vy     = n1_ff.vy;
      n2_in.w      = n1_ff.w;
   end

   always_comb begin
      n3_lsq_in    = {2'b00, n2_ff.nx2} + {2'b00, n2_ff.ny2};
      n3_in.nx     = n2_ff.nx;
      n3_in.ny     = n2_ff.ny;
      n3_in.anx    = n2_ff.anx;
      n3_in.any    = n2_ff.any;
      n3_in.linwin = n2_ff.linwin;
      n3_in.nw     = n2_ff.nw;
      n3_in.angwin = n2_ff.angwin;
      n3_in.dtz    = n2_ff.dtz;
      n3_in.vx     = n2_ff.vx;
      n3_in.vy     = n2_ff.vy;
      n3_in.w      = n2_ff.w;
   end

   // length of the new vector
   bbvc_sqrt #(.IN_W(SQ_IN_W)) u_sqrt_len (
      .clock(clock), .en(advance), .radicand(n3_lsq_ff), .root(len)
   );

   // speed limit test and rescale products
   always_comb begin
      sc_type sc_o;
      sc_o = sc_ff[SQ_LAT-1];
      l1_mulx_in    = sc_o.anx * maxls_ff;
      l1_muly_in    = sc_o.any * maxls_ff;
      l1_in.nx_neg  = sc_o.nx[32];
      l1_in.ny_neg  = sc_o.ny[32];
      l1_in.over    = len >= {2'b00, maxls_ff};
      l1_in.lenz    = (len == '0);
      l1_in.nxl     = sc_o.nx[31:0];
      l1_in.nyl     = sc_o.ny[31:0];
      l1_in.linwin  = sc_o.linwin;
      l1_in.nw      = sc_o.nw;
      l1_in.angwin  = sc_o.angwin;
      l1_in.dtz     = sc_o.dtz;
      l1_in.vx      = sc_o.vx;
      l1_in.vy      = sc_o.vy;
      l1_in.w       = sc_o.w;
   end

   bbvc_div #(.DEN_W(DEN_W), .QUO_W(DIV_LAT)) u_div_sx (
      .clock(clock), .en(advance), .dividend(l1_mulx_ff), .divisor(l1_len_ff),
      .quotient(rx)
   );

   bbvc_div #(.DEN_W(DEN_W), .QUO_W(DIV_LAT)) u_div_sy (
      .clock(clock), .en(advance), .dividend(l1_muly_ff), .divisor(l1_len_ff),
      .quotient(ry)
   );

   // result selection: pass-through, stop windows, new or rescaled vector
   always_comb begin
      sd_type sd_o;
      logic [31:0] rxe, rye, ox, oy, ow;
      sd_o = sd_ff[DIV_LAT-1];
      rxe  = sd_o.nx_neg ? -{1'b0, rx} : {1'b0, rx};
      rye  = sd_o.ny_neg ? -{1'b0, ry} : {1'b0, ry};
      if (sd_o.linwin || (sd_o.over && sd_o.lenz)) begin
         ox = '0;
         oy = '0;
      end else if (sd_o.over) begin
         ox = rxe;
         oy = rye;
      end else begin
         ox = sd_o.nxl;
         oy = sd_o.nyl;
      end
      ow = sd_o.angwin ? '0 : sd_o.nw;
      if (sd_o.dtz) begin
         out_in = {sd_o.w, sd_o.vy, sd_o.vx};
      end else begin
         out_in = {ow, oy, ox};
      end
   end

   // datapath registers, all held together on a stall
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s3_dsq_ff  <= s3_dsq_in;
         sa_ff[0]   <= s3_ff;
         for (int k = 1; k < SQ_LAT; k++) begin
            sa_ff[k] <= sa_ff[k-1];
         end
         p1_ff      <= p1_in;
         p2_ff      <= p2_in;
         p3_ff      <= p3_in;
         p3_numx_ff <= p2_ff.numx;
         p3_numy_ff <= p2_ff.numy;
         p3_dist_ff <= p2_ff.dlen;
         sb_ff[0]   <= p3_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
         n1_ff      <= n1_in;
         n2_ff      <= n2_in;
         n3_ff      <= n3_in;
         n3_lsq_ff  <= n3_lsq_in;
         sc_ff[0]   <= n3_ff;
         for (int k = 1; k < SQ_LAT; k++) begin
            sc_ff[k] <= sc_ff[k-1];
         end
         l1_ff      <= l1_in;
         l1_mulx_ff <= l1_mulx_in;
         l1_muly_ff <= l1_muly_in;
         l1_len_ff  <= len;
         sd_ff[0]   <= l1_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
         out_ff     <= out_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/bbvc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module bbvc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [bbvc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                              csr_valid,
   input wire logic                              csr_ready
);

   // a held result keeps its payload
   `BBVC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp payload changed while stalled")

   // with no result waiting the block takes a command
   `BBVC_ASSERT(a_req_open, clock, reset, !rsp_tvalid |-> req_tready, "req_tready low with empty output")

   // a stalled result freezes the input side
   `BBVC_ASSERT(a_req_stall, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready, "req accepted during a stall")

   // reset empties the pipeline
   `BBVC_ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_tvalid, "result present after reset")

   // register writes never wait
   `BBVC_ASSERT(a_csr_ready, clock, reset, csr_valid |-> csr_ready, "csr write not taken")

endmodule

bind bang_bang_velocity_controller bbvc_checker u_checker (.*);
`default_nettype wire
